FILE: hdl/sgdlr_pkg.sv
// sgdlr_pkg: shared types, constants and fixed-point helpers for the sgd regression block
package sgdlr_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 8;
    localparam int RATE_W  = 20;
    localparam int DIM_W   = 9;
    localparam int ACC_W   = 64;
    localparam int PROD_W  = 64;
    localparam int OPND_W  = 33;
    localparam int WIDE_W  = 66;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // register index taken from paddr[PADDR_W-1]
    localparam logic REG_DIM = 1'b0;

    // result kinds
    localparam logic RESULT_LOSS   = 1'b0;
    localparam logic RESULT_WEIGHT = 1'b1;

    typedef enum logic [1:0] {
        FUNC_FEATURE = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    // operand pairs of the shared multiplier
    typedef enum logic [1:0] {
        MUL_DOT  = 2'd0,
        MUL_RATE = 2'd1,
        MUL_SQ   = 2'd2,
        MUL_GRAD = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     en;
        t_mul_sel sel;
    } t_mul_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/sgdlr_if.sv
// sgdlr_if: valid/ready channel interfaces for sample/weight transactions and results
interface sgdlr_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          func;
    logic [sgdlr_pkg::IDX_W-1:0]         weight_index;
    logic signed [sgdlr_pkg::DATA_W-1:0] data_value;
    logic signed [sgdlr_pkg::DATA_W-1:0] target_value;
    logic [sgdlr_pkg::RATE_W-1:0]        learning_rate;

    modport source (
        output valid, func, weight_index, data_value, target_value, learning_rate,
        input  ready
    );
    modport sink (
        input  valid, func, weight_index, data_value, target_value, learning_rate,
        output ready
    );
endinterface

interface sgdlr_out_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic [sgdlr_pkg::DATA_W-1:0]        sample_loss;
    logic signed [sgdlr_pkg::DATA_W-1:0] weight_read;

    modport source (
        output valid, result_kind, sample_loss, weight_read,
        input  ready
    );
    modport sink (
        input  valid, result_kind, sample_loss, weight_read,
        output ready
    );
endinterface

FILE: hdl/sgdlr_mul.sv
// sgdlr_mul: shared signed multiplier with operand select and registered product
module sgdlr_mul (
    input  logic                                  i_clk,
    input  sgdlr_pkg::t_mul_ctl                   i_ctl,
    input  logic signed [sgdlr_pkg::DATA_W-1:0]   i_weight,
    input  logic signed [sgdlr_pkg::DATA_W-1:0]   i_feature,
    input  logic [sgdlr_pkg::RATE_W-1:0]          i_rate,
    input  logic signed [sgdlr_pkg::DATA_W-1:0]   i_err,
    input  logic signed [sgdlr_pkg::DATA_W-1:0]   i_step,
    input  logic signed [sgdlr_pkg::DATA_W-1:0]   i_buf_x,
    output logic signed [sgdlr_pkg::PROD_W-1:0]   o_prod
);

    logic signed [sgdlr_pkg::OPND_W-1:0] opnd_a;
    logic signed [sgdlr_pkg::OPND_W-1:0] opnd_b;
    logic signed [sgdlr_pkg::WIDE_W-1:0] full;
    logic signed [sgdlr_pkg::PROD_W-1:0] r_prod;

    always_comb begin
        case (i_ctl.sel)
            sgdlr_pkg::MUL_DOT: begin
                opnd_a = 33'(i_weight);
                opnd_b = 33'(i_feature);
            end
            sgdlr_pkg::MUL_RATE: begin
                // rate is unsigned, zero extend into the signed operand
                opnd_a = $signed({{(sgdlr_pkg::OPND_W - sgdlr_pkg::RATE_W){1'b0}}, i_rate});
                opnd_b = 33'(i_err);
            end
            sgdlr_pkg::MUL_SQ: begin
                opnd_a = 33'(i_err);
                opnd_b = 33'(i_err);
            end
            default: begin
                opnd_a = 33'(i_step);
                opnd_b = 33'(i_buf_x);
            end
        endcase
    end

    assign full = opnd_a * opnd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= full[sgdlr_pkg::PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/sgd_linear_regression_step.sv
// sgd_linear_regression_step: fixed-point sgd step of least-squares linear regression
//
//  channel   dir  handshake              carries
//  i_in      in   valid/ready            func, weight_index, data_value, target, rate
//  o_out     out  valid/ready            result_kind, sample_loss, weight_read
//  apb       in   psel/penable/pwrite    dimension_in_use at byte address 0
//
//  a feature transaction reads its weight, then makes one pass through the multiplier;
//  the last feature of a sample then runs sum, error, step, square and loss, and an
//  update pass over its features, one weight per cycle through the shared multiplier
//  weight write is done as it is accepted; weight read waits for the output register
//  i_rst_n is synchronous; memories are not cleared, weights are defined once written
//  a loss or read result waits in its state while the output register is full
module sgd_linear_regression_step #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sgdlr_in_if.sink                         i_in,
    sgdlr_out_if.source                      o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sgdlr_pkg::PADDR_W-1:0]    paddr,
    input  logic [sgdlr_pkg::PDATA_W-1:0]    pwdata,
    output logic [sgdlr_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    // one-hot sequencer
    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_FEAT = 9'b0_0000_0010,  // dot product term through the multiplier
        S_SUM  = 9'b0_0000_0100,  // last term into the accumulator
        S_ERR  = 9'b0_0000_1000,  // round dot, subtract target
        S_STEP = 9'b0_0001_0000,  // rate times error
        S_SQ   = 9'b0_0010_0000,  // saturate step, error squared
        S_LOSS = 9'b0_0100_0000,  // loss into the output register
        S_UPD  = 9'b0_1000_0000,  // weight update pass, one weight per cycle
        S_RDW  = 9'b1_0000_0000   // host weight read result
    } t_state;

    t_state r_state, n_state;

    // config and sample state
    logic [sgdlr_pkg::DIM_W-1:0]          r_dim;
    logic [CW-1:0]                        r_count, n_count;
    logic signed [sgdlr_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic                                 r_prod_vld;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_x;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_tgt;
    logic [sgdlr_pkg::RATE_W-1:0]         r_rate;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_err;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_step;
    logic                                 r_rd_ok;
    logic                                 r_last;

    // update pass pipeline
    logic [CW-1:0]                        r_iss;
    logic                                 r_v1, r_v2;
    logic [AW-1:0]                        r_idx1, r_idx2;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_wold;

    // memories
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_wmem [MAX_DIM];
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_xmem [MAX_DIM];
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_w_rdata;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_x_rdata;

    // output register
    logic                                 r_out_vld;
    logic                                 r_out_kind;
    logic [sgdlr_pkg::DATA_W-1:0]         r_out_loss;
    logic signed [sgdlr_pkg::DATA_W-1:0]  r_out_w;

    logic                                 in_acc;
    logic                                 slot_free;
    logic                                 is_feat, is_wr, is_rd;
    logic                                 idx_ok;
    logic [AW-1:0]                        idx_addr;
    logic [CW-1:0]                        eff_dim;
    logic [AW-1:0]                        pos;
    logic [CW-1:0]                        cnt_next;
    logic                                 last;
    logic                                 issue;
    logic                                 upd_done;

    logic                                 w_we, w_re, x_we, x_re;
    logic [AW-1:0]                        w_wa, w_ra;
    logic signed [sgdlr_pkg::DATA_W-1:0]  w_wd;

    sgdlr_pkg::t_mul_ctl                  mul_ctl;
    logic signed [sgdlr_pkg::PROD_W-1:0]  prod;

    logic signed [sgdlr_pkg::WIDE_W:0]    acc_sum;
    logic signed [sgdlr_pkg::ACC_W-1:0]   acc_sat;
    logic signed [sgdlr_pkg::WIDE_W-1:0]  acc_ext, acc_sh, acc_rb, dot_diff;
    logic signed [sgdlr_pkg::WIDE_W-1:0]  p_ext, p_sh_f, p_rb_f, p_rnd_f;
    logic signed [sgdlr_pkg::WIDE_W-1:0]  p_sh_l, p_rb_l, p_rnd_l;
    logic [sgdlr_pkg::DATA_W-1:0]         loss_val;
    logic signed [sgdlr_pkg::DATA_W-1:0]  new_w;
    logic                                 cfg_wr;

    // ---------------------------------------------------------------- config port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[sgdlr_pkg::PADDR_W-1] == sgdlr_pkg::REG_DIM)
                  ? {{(sgdlr_pkg::PDATA_W - sgdlr_pkg::DIM_W){1'b0}}, r_dim} : '0;

    // ---------------------------------------------------------------- input decode
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_vld || o_out.ready;

    assign is_feat  = (i_in.func == sgdlr_pkg::FUNC_FEATURE);
    assign is_wr    = (i_in.func == sgdlr_pkg::FUNC_WRITE);
    assign is_rd    = (i_in.func == sgdlr_pkg::FUNC_READ);
    assign idx_ok   = (32'(i_in.weight_index) < MAX_DIM);
    assign idx_addr = AW'(i_in.weight_index);

    // dimension 0 acts as 1, anything above the store as the store size
    always_comb begin
        if (r_dim == '0) begin
            eff_dim = CW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            eff_dim = CW'(MAX_DIM);
        end else begin
            eff_dim = CW'(r_dim);
        end
    end

    assign pos      = (32'(r_count) >= MAX_DIM) ? AW'(MAX_DIM - 1) : AW'(r_count);
    assign cnt_next = CW'(pos) + CW'(1);
    assign last     = (cnt_next >= eff_dim);

    assign issue    = (r_state == S_UPD) && (r_iss < r_count);
    assign upd_done = (r_state == S_UPD) && !issue && !r_v1 && !r_v2;

    // ---------------------------------------------------------------- shared multiplier
    always_comb begin
        mul_ctl.en  = 1'b0;
        mul_ctl.sel = sgdlr_pkg::MUL_GRAD;
        unique case (r_state)
            S_FEAT: begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = sgdlr_pkg::MUL_DOT;
            end
            S_STEP: begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = sgdlr_pkg::MUL_RATE;
            end
            S_SQ: begin
                mul_ctl.en  = 1'b1;
                mul_ctl.sel = sgdlr_pkg::MUL_SQ;
            end
            S_UPD: begin
                mul_ctl.en  = r_v1;
                mul_ctl.sel = sgdlr_pkg::MUL_GRAD;
            end
            default: begin
                mul_ctl.en  = 1'b0;
                mul_ctl.sel = sgdlr_pkg::MUL_GRAD;
            end
        endcase
    end

    sgdlr_mul u_mul (
        .i_clk     (i_clk),
        .i_ctl     (mul_ctl),
        .i_weight  (r_w_rdata),
        .i_feature (r_x),
        .i_rate    (r_rate),
        .i_err     (r_err),
        .i_step    (r_step),
        .i_buf_x   (r_x_rdata),
        .o_prod    (prod)
    );

    // ---------------------------------------------------------------- arithmetic
    // saturating accumulate of the pending dot product term
    always_comb begin
        acc_sum = 67'(r_acc) + 67'(prod);
        if (acc_sum[sgdlr_pkg::ACC_W] != acc_sum[sgdlr_pkg::ACC_W-1]) begin
            acc_sat = acc_sum[sgdlr_pkg::ACC_W] ? 64'sh8000_0000_0000_0000
                                                : 64'sh7fff_ffff_ffff_ffff;
        end else begin
            acc_sat = acc_sum[sgdlr_pkg::ACC_W-1:0];
        end
    end

    // dot rounded half up, rounding bit folded in as a carry
    assign acc_ext  = 66'(r_acc);
    assign acc_sh   = acc_ext >>> FRAC_BITS;
    assign acc_rb   = {{(sgdlr_pkg::WIDE_W-1){1'b0}}, r_acc[FRAC_BITS-1]};
    assign dot_diff = acc_sh - 66'(r_tgt) + acc_rb;

    // product narrowed by FRAC_BITS (step, gradient) and by FRAC_BITS+1 (loss)
    assign p_ext   = 66'(prod);
    assign p_sh_f  = p_ext >>> FRAC_BITS;
    assign p_rb_f  = {{(sgdlr_pkg::WIDE_W-1){1'b0}}, prod[FRAC_BITS-1]};
    assign p_rnd_f = p_sh_f + p_rb_f;
    assign p_sh_l  = p_ext >>> (FRAC_BITS + 1);
    assign p_rb_l  = {{(sgdlr_pkg::WIDE_W-1){1'b0}}, prod[FRAC_BITS]};
    assign p_rnd_l = p_sh_l + p_rb_l;

    assign loss_val = (p_rnd_l > 66'sd4294967295) ? '1 : p_rnd_l[sgdlr_pkg::DATA_W-1:0];
    assign new_w    = sgdlr_pkg::sat32(66'(r_wold) - p_rnd_f);

    // ---------------------------------------------------------------- memory ports
    always_comb begin
        w_we = 1'b0;
        w_wa = r_idx2;
        w_wd = new_w;
        if (r_state == S_UPD && r_v2) begin
            w_we = 1'b1;
        end else if (in_acc && is_wr && idx_ok) begin
            w_we = 1'b1;
            w_wa = idx_addr;
            w_wd = i_in.data_value;
        end
    end

    always_comb begin
        w_re = 1'b0;
        w_ra = AW'(r_iss);
        if (issue) begin
            w_re = 1'b1;
        end else if (in_acc && is_feat) begin
            w_re = 1'b1;
            w_ra = pos;
        end else if (in_acc && is_rd && idx_ok) begin
            w_re = 1'b1;
            w_ra = idx_addr;
        end
    end

    assign x_we = in_acc && is_feat;
    assign x_re = issue;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_w_rdata <= r_wmem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_xmem[pos] <= i_in.data_value;
        end
        if (x_re) begin
            r_x_rdata <= r_xmem[AW'(r_iss)];
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_feat) begin
                    n_state = S_FEAT;
                end else if (in_acc && is_rd) begin
                    n_state = S_RDW;
                end
            end
            S_FEAT: n_state = r_last ? S_SUM : S_IDLE;
            S_SUM:  n_state = S_ERR;
            S_ERR:  n_state = S_STEP;
            S_STEP: n_state = S_SQ;
            S_SQ:   n_state = S_LOSS;
            S_LOSS: begin
                if (slot_free) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (upd_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RDW: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (in_acc && is_feat) begin
            n_count = cnt_next;
        end else if (upd_done) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_prod_vld) begin
            n_acc = acc_sat;
        end else if (upd_done) begin
            n_acc = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dim      <= sgdlr_pkg::DIM_RESET;
            r_count    <= '0;
            r_acc      <= '0;
            r_prod_vld <= 1'b0;
            r_iss      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_acc      <= n_acc;
            r_prod_vld <= (r_state == S_FEAT);
            r_v1       <= issue;
            r_v2       <= r_v1;
            if (cfg_wr && paddr[sgdlr_pkg::PADDR_W-1] == sgdlr_pkg::REG_DIM) begin
                r_dim <= pwdata[sgdlr_pkg::DIM_W-1:0];
            end
            if (r_state == S_LOSS) begin
                r_iss <= '0;
            end else if (issue) begin
                r_iss <= r_iss + CW'(1);
            end
            if ((r_state == S_LOSS || r_state == S_RDW) && slot_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && is_feat) begin
            r_x    <= i_in.data_value;
            r_tgt  <= i_in.target_value;
            r_rate <= i_in.learning_rate;
            r_last <= last;
        end
        if (in_acc && is_rd) begin
            r_rd_ok <= idx_ok;
        end
        if (r_state == S_ERR) begin
            r_err <= sgdlr_pkg::sat32(dot_diff);
        end
        if (r_state == S_SQ) begin
            r_step <= sgdlr_pkg::sat32(p_rnd_f);
        end
        if (issue) begin
            r_idx1 <= AW'(r_iss);
        end
        if (r_v1) begin
            r_idx2 <= r_idx1;
            r_wold <= r_w_rdata;
        end
        if (r_state == S_LOSS && slot_free) begin
            r_out_kind <= sgdlr_pkg::RESULT_LOSS;
            r_out_loss <= loss_val;
            r_out_w    <= '0;
        end else if (r_state == S_RDW && slot_free) begin
            r_out_kind <= sgdlr_pkg::RESULT_WEIGHT;
            r_out_loss <= '0;
            r_out_w    <= r_rd_ok ? r_w_rdata : '0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.result_kind = r_out_kind;
    assign o_out.sample_loss = r_out_loss;
    assign o_out.weight_read = r_out_w;

`ifndef SYNTH
    // a dot product term is folded into the accumulator exactly once
    a_prod_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |=> !r_prod_vld)
        else $error("dot product term pending for two cycles");

    // the feature count never passes the store size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_DIM)
        else $error("feature count beyond store size");

    // leaving the update pass clears the sample state
    a_sample_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && n_state == S_IDLE) |=> (r_count == '0 && r_acc == '0))
        else $error("sample state not cleared after update");

    // the loss lands in the output register as the update pass starts
    a_loss_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOSS && slot_free) |=>
            (o_out.valid && o_out.result_kind == sgdlr_pkg::RESULT_LOSS))
        else $error("loss result not presented");

    // the weight memory write port is never shared between host and update pass
    a_wport: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_state == S_UPD) |-> !in_acc)
        else $error("host transaction during weight update");
`endif

endmodule

FILE: tb/sgdlr_result_checker.sv
// sgdlr_result_checker: passive mirror of the sgd step block that checks every result transaction
`timescale 1ns / 100ps

module sgdlr_result_checker
    import sgdlr_pkg::*;
#(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sgdlr_in_if                i_in,
    sgdlr_out_if               i_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    output int                 o_fail_count,
    output int                 o_owed,
    output int                 o_losses_checked,
    output int                 o_reads_checked
);

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint U32_HI = 64'sd4294967295;
    localparam longint S64_HI = 64'sh7fff_ffff_ffff_ffff;
    localparam longint S64_LO = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] loss;
        logic [DATA_W-1:0] wread;
    } sgd_output_t;

    // mirrored block state
    logic signed [DATA_W-1:0] w_mirror [MAX_DIM];
    logic signed [DATA_W-1:0] x_mirror [MAX_DIM];
    longint                   dot_acc;
    int unsigned              feat_cnt;
    logic [DIM_W-1:0]         dim_reg;

    sgd_output_t owed_outputs [$];
    int fail_cnt   = 0;
    int loss_cnt   = 0;
    int read_cnt   = 0;

    function automatic longint clamp32(input longint v);
        if (v > S32_HI) return S32_HI;
        if (v < S32_LO) return S32_LO;
        return v;
    endfunction

    function automatic longint add_sat64(input longint a, input longint b);
        if (b > 0 && a > S64_HI - b) return S64_HI;
        if (b < 0 && a < S64_LO - b) return S64_LO;
        return a + b;
    endfunction

    // floor(v / 2^s + 1/2)
    function automatic longint round_shift(input longint v, input int s);
        return (v >>> s) + (v[s-1] ? 64'sd1 : 64'sd0);
    endfunction

    function automatic void flag_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
        fail_cnt++;
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    endfunction

    function automatic void compute_sgd_step(input logic [1:0] fn, input logic [IDX_W-1:0] idx,
                                             input logic signed [DATA_W-1:0] data,
                                             input logic signed [DATA_W-1:0] tgt,
                                             input logic [RATE_W-1:0] rate);
        sgd_output_t res;
        int unsigned lim, pos, k;
        longint dot, err, stp, grad, upd, sq;
        res = '0;
        case (fn)
            FUNC_WRITE: begin
                if (idx < MAX_DIM) w_mirror[idx] = data;
            end
            FUNC_READ: begin
                res.kind  = RESULT_WEIGHT;
                res.wread = (idx < MAX_DIM) ? w_mirror[idx] : '0;
                owed_outputs.push_back(res);
            end
            FUNC_FEATURE: begin
                lim = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
                pos = (feat_cnt >= MAX_DIM) ? MAX_DIM - 1 : feat_cnt;
                x_mirror[pos] = data;
                dot_acc  = add_sat64(dot_acc, longint'(w_mirror[pos]) * longint'(data));
                feat_cnt = pos + 1;
                if (feat_cnt >= lim) begin
                    dot = round_shift(dot_acc, FRAC_BITS);
                    err = clamp32(dot - longint'(tgt));
                    stp = clamp32(round_shift(longint'({44'd0, rate}) * err, FRAC_BITS));
                    for (k = 0; k < feat_cnt; k++) begin
                        grad = round_shift(stp * longint'(x_mirror[k]), FRAC_BITS);
                        upd  = clamp32(longint'(w_mirror[k]) - grad);
                        w_mirror[k] = upd[DATA_W-1:0];
                    end
                    // half the squared error: one extra bit of shift
                    sq = round_shift(err * err, FRAC_BITS + 1);
                    if (sq > U32_HI) sq = U32_HI;
                    res.kind = RESULT_LOSS;
                    res.loss = sq[DATA_W-1:0];
                    owed_outputs.push_back(res);
                    dot_acc  = 0;
                    feat_cnt = 0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        sgd_output_t due;
        if (!i_rst_n) begin
            owed_outputs.delete();
            dot_acc  = 0;
            feat_cnt = 0;
            dim_reg  = DIM_RESET;
        end else begin
            // results first, so an item accepted at this edge cannot satisfy them
            if (i_out.valid && i_out.ready) begin
                if (owed_outputs.size() == 0) begin
                    fail_cnt++;
                    $display("%0t ns: result with nothing owed, expected none actual kind %0d %h %h",
                             $time, i_out.result_kind, i_out.sample_loss, i_out.weight_read);
                end else begin
                    due = owed_outputs.pop_front();
                    if (i_out.result_kind !== due.kind)
                        flag_field("result_kind", due.kind, i_out.result_kind);
                    if (i_out.sample_loss !== due.loss)
                        flag_field("sample_loss", due.loss, i_out.sample_loss);
                    if (i_out.weight_read !== due.wread)
                        flag_field("weight_read", due.wread, i_out.weight_read);
                    if (due.kind == RESULT_LOSS) loss_cnt++;
                    else read_cnt++;
                end
            end
            if (i_in.valid && i_in.ready)
                compute_sgd_step(i_in.func, i_in.weight_index, i_in.data_value,
                                 i_in.target_value, i_in.learning_rate);
            if (psel && penable && pready && paddr[PADDR_W-1] == REG_DIM) begin
                if (pwrite) dim_reg = pwdata[DIM_W-1:0];
                else if (prdata[DIM_W-1:0] !== dim_reg)
                    flag_field("dimension_in_use", dim_reg, prdata[DIM_W-1:0]);
            end
        end
        o_fail_count     <= fail_cnt;
        o_owed           <= owed_outputs.size();
        o_losses_checked <= loss_cnt;
        o_reads_checked  <= read_cnt;
    end

endmodule

FILE: tb/tb.sv
// tb: stimulus, handshake pacing and verdict for the sgd linear regression step block
`timescale 1ns / 100ps

module tb;
    import sgdlr_pkg::*;

    localparam int MAX_DIM      = 256;
    localparam int FRAC_BITS    = 16;
    localparam int IDLE_PCT     = 33;
    localparam int RANDOM_ITEMS = 1300;
    // last feature of a full sample runs an update pass over all MAX_DIM weights; leave margin
    localparam int SETTLE_CYCLES = MAX_DIM + 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [PADDR_W-1:0] DIM_ADDR = {REG_DIM, {(PADDR_W-1){1'b0}}};

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sgdlr_in_if  in_ch ();
    sgdlr_out_if out_ch ();

    int chk_fails;
    int chk_owed;
    int chk_losses;
    int chk_reads;

    // pacing controls shared between the stimulus and the result receiver
    bit steady       = 1'b0;
    bit pressure_go  = 1'b0;
    int cycle_count  = 0;

    // transaction tallies for the summary
    int n_features   = 0;
    int n_writes     = 0;
    int n_reads      = 0;
    int n_unused     = 0;
    int n_dim_writes = 0;

    sgd_linear_regression_step #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sgdlr_result_checker #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) result_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (in_ch),
        .i_out            (out_ch),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .o_fail_count     (chk_fails),
        .o_owed           (chk_owed),
        .o_losses_checked (chk_losses),
        .o_reads_checked  (chk_reads)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results still owed",
                     cycle_count, chk_owed);
            $display("Mismatches found");
            $finish;
        end
    end

    // q16.16 values: mostly near +/-2 so updates stay moderate, some full range and rails
    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return DATA_W'($urandom_range(0, 1 << 18)) - DATA_W'(1 << 17);
        endcase
    endfunction

    // learning rate: mostly small steps, now and then anything in the 20-bit range
    function automatic logic [RATE_W-1:0] rand_rate();
        case ($urandom_range(0, 9))
            0:       return RATE_W'($urandom());
            1, 2:    return RATE_W'($urandom_range(0, 65536));
            default: return RATE_W'($urandom_range(0, 4096));
        endcase
    endfunction

    // offer one transaction, with random idle cycles ahead of it unless pacing is steady
    task automatic send_item(input logic [1:0] fn, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data, input logic [DATA_W-1:0] tgt,
                             input logic [RATE_W-1:0] rate);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= fn;
        in_ch.weight_index  <= idx;
        in_ch.data_value    <= data;
        in_ch.target_value  <= tgt;
        in_ch.learning_rate <= rate;
        do @(posedge i_clk); while (!in_ch.ready);
        case (fn)
            FUNC_FEATURE: n_features++;
            FUNC_WRITE:   n_writes++;
            FUNC_READ:    n_reads++;
            default:      n_unused++;
        endcase
    endtask

    // wait until every owed result has come back, then let the update pass drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of dimension_in_use followed by a read back; upper data bits are noise
    task automatic write_dim(input logic [DIM_W-1:0] dim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIM_ADDR;
        pwdata  <= {PDATA_W'($urandom()) >> DIM_W << DIM_W} | PDATA_W'(dim);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        n_dim_writes++;
    endtask

    // a random mix: mostly features that build whole samples, some weight access, some noise
    task automatic run_mixed(input int count, input int feature_pct);
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < feature_pct)
                send_item(FUNC_FEATURE, $urandom(), rand_q16(), rand_q16(), rand_rate());
            else if (pick < feature_pct + (100 - feature_pct) * 4 / 10)
                send_item(FUNC_WRITE, $urandom(), rand_q16(), rand_q16(), rand_rate());
            else if (pick < 97)
                send_item(FUNC_READ, $urandom(), $urandom(), $urandom(), $urandom());
            else
                send_item(FUNC_NONE, $urandom(), $urandom(), $urandom(), $urandom());
        end
    endtask

    // result receiver: random back-pressure, one long hold-off when the stimulus asks
    initial begin
        int  hold_left;
        bit  pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_go && !pressure_done) begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int               k;
        int               phase;
        int               items_at_start;
        int               total_fail;
        logic [DIM_W-1:0] dim_pick;

        // every input known from time zero
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.func          <= FUNC_NONE;
        in_ch.weight_index  <= '0;
        in_ch.data_value    <= '0;
        in_ch.target_value  <= '0;
        in_ch.learning_rate <= '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // weights are undefined until written: load all of them before any sample
        for (k = 0; k < MAX_DIM; k++)
            send_item(FUNC_WRITE, k, rand_q16(), rand_q16(), rand_rate());
        settle();

        // directed: two-feature samples
        write_dim(2);
        send_item(FUNC_READ, 8'h00, 32'h0, 32'h0, 20'h0);
        send_item(FUNC_READ, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 20'hfffff);
        // most negative weights times most negative features overflow the accumulator
        send_item(FUNC_WRITE, 8'h00, 32'h8000_0000, 32'h0, 20'h0);
        send_item(FUNC_WRITE, 8'h01, 32'h8000_0000, 32'h0, 20'h0);
        send_item(FUNC_FEATURE, 8'hff, 32'h8000_0000, 32'h0, 20'h0);
        // full rate on a railed error saturates the step, the weights and the loss
        send_item(FUNC_FEATURE, 8'h00, 32'h8000_0000, 32'h7fff_ffff, 20'hfffff);
        send_item(FUNC_READ, 8'h00, 32'h0, 32'h0, 20'h0);
        send_item(FUNC_READ, 8'h01, 32'h0, 32'h0, 20'h0);
        // unused function code: nothing happens
        send_item(FUNC_NONE, 8'h5a, 32'h1234_5678, 32'h8765_4321, 20'h5a5a5);
        send_item(FUNC_WRITE, 8'h00, 32'h7fff_ffff, 32'h0, 20'h0);
        send_item(FUNC_FEATURE, 8'h00, 32'h7fff_ffff, 32'h0, 20'h0);
        // zero rate: weights hold, loss from the most negative target
        send_item(FUNC_FEATURE, 8'h00, 32'h0, 32'h8000_0000, 20'h0);
        // weight write and read in the middle of a sample leave it intact
        send_item(FUNC_FEATURE, 8'h00, 32'h0001_0000, 32'h0, 20'h0);
        send_item(FUNC_WRITE, 8'h01, 32'h0002_0000, 32'h0, 20'h0);
        send_item(FUNC_READ, 8'h01, 32'h0, 32'h0, 20'h0);
        send_item(FUNC_FEATURE, 8'h00, 32'hffff_0000, 32'h0000_8000, 20'h08000);
        settle();

        // dimension shrinks below the features already taken: next feature closes the sample
        write_dim(8);
        for (k = 0; k < 5; k++)
            send_item(FUNC_FEATURE, k, rand_q16(), rand_q16(), rand_rate());
        settle();
        write_dim(3);
        send_item(FUNC_FEATURE, 8'h05, rand_q16(), 32'h0001_0000, 20'h01000);
        send_item(FUNC_READ, 8'h05, 32'h0, 32'h0, 20'h0);
        settle();

        // dimension zero behaves as one: every feature is a sample
        write_dim(0);
        send_item(FUNC_FEATURE, 8'h00, 32'h0000_8000, 32'h0, 20'h10000);
        send_item(FUNC_FEATURE, 8'h00, 32'hffff_8000, 32'h7fff_ffff, 20'hfffff);
        settle();

        // random phases; two of them run full-size samples, two steady, one of those with a hold-off
        items_at_start = n_features + n_writes + n_reads;
        phase = 0;
        while (n_features + n_writes + n_reads - items_at_start < RANDOM_ITEMS) begin
            if (phase == 3) begin
                dim_pick = MAX_DIM;
            end else if (phase == 11) begin
                dim_pick = '1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       dim_pick = 0;
                    1:       dim_pick = 1;
                    2, 3, 4: dim_pick = $urandom_range(2, 8);
                    5, 6, 7: dim_pick = $urandom_range(9, 40);
                    default: dim_pick = $urandom_range(41, 96);
                endcase
            end
            write_dim(dim_pick);
            steady = (phase == 5 || phase == 8);
            if (phase == 8) begin
                // block fills up behind a stalled receiver
                pressure_go = 1'b1;
                for (k = 0; k < 30; k++)
                    send_item(FUNC_READ, $urandom(), $urandom(), $urandom(), $urandom());
            end
            if (phase == 3 || phase == 11)
                run_mixed(300, 97);
            else
                run_mixed($urandom_range(30, 90), 80);
            settle();
            steady = 1'b0;
            phase++;
        end

        $display("sent %0d features, %0d weight writes, %0d weight reads, %0d unused codes",
                 n_features, n_writes, n_reads, n_unused);
        $display("checked %0d losses and %0d weight reads over %0d dimension settings",
                 chk_losses, chk_reads, n_dim_writes);
        total_fail = chk_fails + chk_owed;
        if (chk_owed != 0)
            $display("%0d results never arrived", chk_owed);
        if (total_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/sgdlr_pkg.sv
hdl/sgdlr_if.sv
hdl/sgdlr_mul.sv
hdl/sgd_linear_regression_step.sv
tb/sgdlr_result_checker.sv
tb/tb.sv
